@@ hdl/utt_pkg.sv @@
`default_nettype none
package utt_pkg;

  localparam int unsigned UTT_FIFO_DEPTH = 4;

  localparam logic [15:0] UTT_CR        = 16'd13;
  localparam logic [5:0]  UTT_HIGH_TAG  = 6'b110110;
  localparam logic [5:0]  UTT_LOW_TAG   = 6'b110111;
  localparam logic [20:0] UTT_SUPP_BASE = 21'h10000;
  localparam logic [15:0] UTT_TWO_MIN   = 16'h0080;
  localparam logic [15:0] UTT_THREE_MIN = 16'h0800;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } utt_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       malformed;
  } utt_out_t;

  typedef enum logic [2:0] {
    KIND_ERR,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_FOUR
  } utt_kind_t;

  typedef struct packed {
    utt_kind_t   kind;
    logic [20:0] scalar;
  } utt_job_t;

  typedef struct packed {
    logic job_valid;
    logic pending;
  } utt_front_stat_t;

  // byte idx of the utf-8 sequence a job stands for
  function automatic utt_out_t utt_byte(input utt_job_t job, input logic [1:0] idx);
    utt_out_t r;
    r = '{out_byte: 8'd0, last_of_run: 1'b0, malformed: 1'b0};
    unique case (job.kind)
      KIND_ERR: begin
        r.last_of_run = 1'b1;
        r.malformed   = 1'b1;
      end
      KIND_ONE: begin
        r.out_byte    = {1'b0, job.scalar[6:0]};
        r.last_of_run = 1'b1;
      end
      KIND_TWO: begin
        if (idx == 2'd0) begin
          r.out_byte = {3'b110, job.scalar[10:6]};
        end else begin
          r.out_byte    = {2'b10, job.scalar[5:0]};
          r.last_of_run = 1'b1;
        end
      end
      KIND_THREE: begin
        unique case (idx)
          2'd0:    r.out_byte = {4'b1110, job.scalar[15:12]};
          2'd1:    r.out_byte = {2'b10, job.scalar[11:6]};
          default: begin
            r.out_byte    = {2'b10, job.scalar[5:0]};
            r.last_of_run = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: r.out_byte = {5'b11110, job.scalar[20:18]};
          2'd1: r.out_byte = {2'b10, job.scalar[17:12]};
          2'd2: r.out_byte = {2'b10, job.scalar[11:6]};
          default: begin
            r.out_byte    = {2'b10, job.scalar[5:0]};
            r.last_of_run = 1'b1;
          end
        endcase
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/utt_front.sv @@
`default_nettype none
module utt_front import utt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire utt_in_t         item,
  output utt_front_stat_t      stat,
  output utt_job_t             job
);

  logic       pending, pending_next;
  logic [9:0] high_bits, high_bits_next;
  logic       job_valid;
  logic [15:0] c;

  assign c = item.code_unit;

  always_comb begin
    job_valid      = 1'b0;
    job            = '{kind: KIND_ERR, scalar: {5'd0, c}};
    pending_next   = pending;
    high_bits_next = high_bits;
    if (pending) begin
      pending_next   = 1'b0;
      high_bits_next = 10'd0;
      job_valid      = 1'b1;
      if (c[15:10] == UTT_LOW_TAG) begin
        job.kind   = KIND_FOUR;
        job.scalar = UTT_SUPP_BASE + {1'b0, high_bits, c[9:0]};
      end
    end else if (c == UTT_CR) begin
      job_valid = 1'b0;
    end else if (c[15:10] == UTT_HIGH_TAG) begin
      if (item.final_unit) begin
        job_valid = 1'b1;
      end else begin
        pending_next   = 1'b1;
        high_bits_next = c[9:0];
      end
    end else if (c[15:10] == UTT_LOW_TAG || c == 16'd0) begin
      job_valid = 1'b1;
    end else begin
      job_valid = 1'b1;
      if (c < UTT_TWO_MIN) begin
        job.kind = KIND_ONE;
      end else if (c < UTT_THREE_MIN) begin
        job.kind = KIND_TWO;
      end else begin
        job.kind = KIND_THREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      high_bits <= 10'd0;
    end else if (accept) begin
      pending   <= pending_next;
      high_bits <= high_bits_next;
    end
  end

  assign stat.job_valid = accept && job_valid;
  assign stat.pending   = pending;

endmodule
`default_nettype wire

@@ hdl/utt_fifo.sv @@
`default_nettype none
module utt_fifo import utt_pkg::*; #(
  parameter int unsigned DEPTH = UTT_FIFO_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire utt_job_t wr_job,
  input  wire logic     rd,
  output utt_job_t      head,
  output logic          full,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utt_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/utt_back.sv @@
`default_nettype none
module utt_back import utt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire utt_job_t head,
  input  wire logic     job_empty,
  output logic          job_pop,
  output logic          empty,
  input  wire logic     pop,
  output utt_out_t      result
);

  logic       res_valid;
  logic [1:0] idx;
  logic       load;
  utt_out_t   next_word;

  assign next_word = utt_byte(head, idx);
  // output slot frees up when it is empty or being taken this cycle
  assign load    = !job_empty && (!res_valid || pop);
  assign job_pop = load && next_word.last_of_run;
  assign empty   = !res_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= next_word.last_of_run ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/utf16_to_utf8_transcoder.sv @@
`default_nettype none
// utf-16 to utf-8 transcoder. each accepted word is one utf-16 code unit; the
// front end classifies it in the cycle it is taken, keeps a held high surrogate,
// and queues one job per unit that yields output. the back end turns a job into
// 1 to 4 utf-8 bytes at one byte per cycle, while the receiver pops, through a
// registered output word, so a unit uses output bandwidth by its encoded length;
// carriage returns and held high surrogates are accepted and yield nothing.
// errors (lone low surrogate, broken pair, high surrogate on the final unit, zero
// unit) yield one word with malformed set, out_byte zero and last_of_run set.
// full rises only when the job queue of FIFO_DEPTH entries is full.
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = UTT_FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  output logic         full,
  input  wire utt_in_t item,
  output logic         empty,
  input  wire logic    pop,
  output utt_out_t     result
);

  utt_front_stat_t fstat;
  utt_job_t        fjob, head;
  logic            accept, job_empty, job_pop;

  assign accept = push && !full;

  utt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .stat   (fstat),
    .job    (fjob)
  );

  utt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (fstat.job_valid),
    .wr_job (fjob),
    .rd     (job_pop),
    .head   (head),
    .full   (full),
    .empty  (job_empty)
  );

  utt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

`ifndef ASSERT_OFF
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.malformed) |-> (result.last_of_run && result.out_byte == 8'd0))
    else $error("error word carries data or is not last");

  a_hold_high: assert property (@(posedge clk) disable iff (rst)
    (accept && !fstat.pending && item.code_unit[15:10] == UTT_HIGH_TAG && !item.final_unit)
    |=> fstat.pending)
    else $error("high surrogate not held");

  a_pair_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && fstat.pending) |-> (fstat.job_valid ##1 !fstat.pending))
    else $error("held surrogate not resolved by next unit");

  a_no_job_held: assert property (@(posedge clk) disable iff (rst)
    (accept && !fstat.pending && item.code_unit[15:10] == UTT_HIGH_TAG && !item.final_unit)
    |-> !fstat.job_valid)
    else $error("job queued for a held high surrogate");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import utt_pkg::*;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // expected utf-8 bytes for the code units taken by the block
  class utf8_byte_board;
    bit         pending;
    bit [9:0]   high_held;
    utt_out_t   expected_bytes[$];
    int         errors;
    int         units_seen;
    int         words_checked;
    int         malformed_seen;

    function new();
      pending        = 1'b0;
      high_held      = '0;
      errors         = 0;
      units_seen     = 0;
      words_checked  = 0;
      malformed_seen = 0;
    endfunction

    function void add_byte(logic [7:0] b, logic last);
      utt_out_t w;
      w = '{out_byte: b, last_of_run: last, malformed: 1'b0};
      expected_bytes = {expected_bytes, w};
    endfunction

    function void add_error();
      utt_out_t w;
      pending   = 1'b0;
      high_held = '0;
      w = '{out_byte: 8'd0, last_of_run: 1'b1, malformed: 1'b1};
      expected_bytes = {expected_bytes, w};
    endfunction

    function void add_scalar(logic [20:0] c);
      if (c < 21'(UTT_TWO_MIN)) begin
        add_byte(8'(c), 1'b1);
      end else if (c < 21'(UTT_THREE_MIN)) begin
        add_byte(8'hc0 | 8'(c >> 6), 1'b0);
        add_byte(8'h80 | 8'(c & 21'd63), 1'b1);
      end else if (c < UTT_SUPP_BASE) begin
        add_byte(8'he0 | 8'(c >> 12), 1'b0);
        add_byte(8'h80 | 8'((c >> 6) & 21'd63), 1'b0);
        add_byte(8'h80 | 8'(c & 21'd63), 1'b1);
      end else begin
        add_byte(8'hf0 | 8'(c >> 18), 1'b0);
        add_byte(8'h80 | 8'((c >> 12) & 21'd63), 1'b0);
        add_byte(8'h80 | 8'((c >> 6) & 21'd63), 1'b0);
        add_byte(8'h80 | 8'(c & 21'd63), 1'b1);
      end
    endfunction

    function void note_unit(utt_in_t u);
      logic [20:0] scalar;
      units_seen++;
      if (pending) begin
        // the unit after a high surrogate is always consumed as its partner
        if (u.code_unit[15:10] != UTT_LOW_TAG) begin
          add_error();
        end else begin
          scalar    = UTT_SUPP_BASE + 21'({high_held, u.code_unit[9:0]});
          pending   = 1'b0;
          high_held = '0;
          add_scalar(scalar);
        end
      end else if (u.code_unit == UTT_CR) begin
        // carriage return is dropped
      end else if (u.code_unit[15:10] == UTT_HIGH_TAG) begin
        if (u.final_unit) begin
          add_error();
        end else begin
          pending   = 1'b1;
          high_held = u.code_unit[9:0];
        end
      end else if (u.code_unit[15:10] == UTT_LOW_TAG || u.code_unit == 16'd0) begin
        add_error();
      end else begin
        add_scalar(21'(u.code_unit));
      end
    endfunction

    function void check_word(utt_out_t got);
      utt_out_t want;
      words_checked++;
      if (got.malformed) malformed_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected: byte=%02h last=%b malformed=%b",
                 $time, got.out_byte, got.last_of_run, got.malformed);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, got.out_byte);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                 got.last_of_run);
      end
      if (got.malformed !== want.malformed) begin
        errors++;
        $display("%0t: malformed expected %b actual %b", $time, want.malformed, got.malformed);
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     push;
  logic     full;
  utt_in_t  item;
  logic     empty;
  logic     pop;
  utt_out_t result;

  bit             rx_hold_req;
  int             idle_cycles;
  int             full_stalls;
  utf8_byte_board board;

  utf16_to_utf8_transcoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    board       = new();
    idle_cycles = 0;
    full_stalls = 0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && push && !full) board.note_unit(item);
    if (!rst && pop && !empty) board.check_word(result);
    if (!rst && push && full) full_stalls++;
    if (!rst && ((push && !full) || (pop && !empty))) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // receiver: random bursts and gaps, plus one long hold-off on request
  initial begin
    int burst;
    int hold;
    pop   = 1'b0;
    burst = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold        = RX_HOLD_CYCLES;
        burst       = 0;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (burst > 0) begin
        pop <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 1) != 0) begin
        burst = $urandom_range(1, 30);
        pop <= 1'b1;
      end else begin
        hold = gap_cycles();
        pop <= 1'b0;
      end
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic fin);
    item <= '{code_unit: cu, final_unit: fin};
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic pace(input bit busy);
    int n;
    n = busy ? 0 : gap_cycles();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic put_unit(input logic [15:0] cu, input logic fin, input bit busy);
    send_unit(cu, fin);
    pace(busy);
  endtask

  // drop push and wait for the clock first so the last taken unit is already on the board
  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // one character of text, mostly well formed, sometimes broken
  task automatic send_char(input bit busy);
    int          r;
    int          sub;
    logic        fin;
    logic [15:0] cu;
    r   = $urandom_range(0, 99);
    sub = $urandom_range(0, 3);
    fin = ($urandom_range(0, 9) == 0);
    if (r < 25) begin
      put_unit(16'($urandom_range(1, 127)), fin, busy);
    end else if (r < 40) begin
      put_unit(16'($urandom_range(16'h0080, 16'h07ff)), fin, busy);
    end else if (r < 55) begin
      cu = 16'($urandom_range(16'h0800, 16'hffff));
      if (cu[15:11] == 5'b11011) cu = cu ^ 16'h2000;
      put_unit(cu, fin, busy);
    end else if (r < 80) begin
      put_unit({UTT_HIGH_TAG, 10'($urandom)}, ($urandom_range(0, 19) == 0), busy);
      put_unit({UTT_LOW_TAG, 10'($urandom)}, fin, busy);
    end else if (r < 85) begin
      put_unit(UTT_CR, fin, busy);
    end else if (sub == 0) begin
      put_unit(16'($urandom), fin, busy);
    end else if (sub == 1) begin
      put_unit(16'd0, fin, busy);
    end else if (sub == 2) begin
      put_unit({UTT_LOW_TAG, 10'($urandom)}, fin, busy);
    end else begin
      put_unit({UTT_HIGH_TAG, 10'($urandom)}, 1'b0, busy);
      put_unit(16'($urandom), fin, busy);
    end
  endtask

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    item        = '0;
    rx_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encoding length boundaries
    put_unit(16'h0041, 1'b0, 1'b0);
    put_unit(16'h0001, 1'b0, 1'b0);
    put_unit(16'h007f, 1'b0, 1'b0);
    put_unit(16'h0080, 1'b0, 1'b0);
    put_unit(16'h07ff, 1'b0, 1'b0);
    put_unit(16'h0800, 1'b0, 1'b0);
    put_unit(16'hd7ff, 1'b0, 1'b0);
    put_unit(16'he000, 1'b0, 1'b0);
    put_unit(16'hffff, 1'b1, 1'b0);
    // carriage returns vanish, a zero unit is malformed
    put_unit(UTT_CR, 1'b0, 1'b0);
    put_unit(UTT_CR, 1'b1, 1'b0);
    put_unit(16'h0000, 1'b0, 1'b0);
    // lowest and highest surrogate pairs, final flag on the low half, then a lone low
    put_unit(16'hd800, 1'b0, 1'b0);
    put_unit(16'hdc00, 1'b0, 1'b0);
    put_unit(16'hdbff, 1'b0, 1'b0);
    put_unit(16'hdfff, 1'b1, 1'b0);
    put_unit(16'hdc00, 1'b0, 1'b0);
    // broken pairs: partner is plain, cr, zero or another high; also a high on the final unit
    put_unit(16'hd834, 1'b0, 1'b0);
    put_unit(16'h0041, 1'b0, 1'b0);
    put_unit(16'hd800, 1'b0, 1'b0);
    put_unit(UTT_CR, 1'b0, 1'b0);
    put_unit(16'hd800, 1'b0, 1'b0);
    put_unit(16'h0000, 1'b0, 1'b0);
    put_unit(16'hdbff, 1'b1, 1'b0);
    put_unit(16'hd800, 1'b0, 1'b0);
    put_unit(16'hdbff, 1'b0, 1'b0);

    repeat (40) send_char(1'b0);

    // back up the block while the receiver is held off
    drain_all();
    rx_hold_req = 1'b1;
    repeat (25) send_char(1'b1);
    drain_all();

    repeat (30) send_char(1'b1);
    repeat (40) send_char(1'b0);

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d code units, %0d output words of which %0d malformed",
             board.units_seen, board.words_checked, board.malformed_seen);
    $display("input held off by full on %0d cycles, %0d mismatches, %0d words left over",
             full_stalls, board.errors, board.outstanding());
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
